@@ hdl/rsa_signature_padding_check_assert.svh @@
// assertion macros used by the padding check top module
`ifndef RSA_SIGNATURE_PADDING_CHECK_ASSERT_SVH
`define RSA_SIGNATURE_PADDING_CHECK_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RSAPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSAPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rsapc_pkg.sv @@
// types, constants and prefix tables for the rsa signature padding check
package rsapc_pkg;

  localparam int HashBytes     = 20;
  localparam int MaxBlockBytes = 512;
  localparam int LongLen       = 15;
  localparam int ShortLen      = 13;
  localparam int WinLen        = 16;
  localparam int WinBase       = HashBytes;
  localparam int LastWinPos    = HashBytes + WinLen - 1;
  localparam int PosW          = $clog2(MaxBlockBytes + 1);
  localparam int HashIdxW      = $clog2(HashBytes);
  localparam int WinIdxW       = $clog2(WinLen);
  localparam int MsW           = 9;
  localparam int MsReset       = 256;
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 32;

  localparam logic [7:0] ByteFf   = 8'hff;
  localparam logic [7:0] ByteOne  = 8'h01;
  localparam logic [7:0] ByteZero = 8'h00;

  localparam logic ReqHash  = 1'b0;
  localparam logic ReqBlock = 1'b1;

  localparam logic RegModulusSize = 1'b0;

  typedef enum logic [1:0] {
    FAIL_NONE  = 2'd0,
    FAIL_HASH  = 2'd1,
    FAIL_PAD   = 2'd2,
    FAIL_SHORT = 2'd3
  } fail_reason_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       signature_ok;
    logic [1:0] fail_reason;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } hash_wr_t;

  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] data;
  } blk_op_t;

  function automatic logic [7:0] long_prefix_byte(input logic [WinIdxW-1:0] k);
    logic [7:0] r;
    case (k)
      4'd0:    r = 8'h14;
      4'd1:    r = 8'h04;
      4'd2:    r = 8'h00;
      4'd3:    r = 8'h05;
      4'd4:    r = 8'h1a;
      4'd5:    r = 8'h02;
      4'd6:    r = 8'h03;
      4'd7:    r = 8'h0e;
      4'd8:    r = 8'h2b;
      4'd9:    r = 8'h05;
      4'd10:   r = 8'h06;
      4'd11:   r = 8'h09;
      4'd12:   r = 8'h30;
      4'd13:   r = 8'h21;
      4'd14:   r = 8'h30;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] short_prefix_byte(input logic [WinIdxW-1:0] k);
    logic [7:0] r;
    case (k)
      4'd0:    r = 8'h14;
      4'd1:    r = 8'h04;
      4'd2:    r = 8'h1a;
      4'd3:    r = 8'h02;
      4'd4:    r = 8'h03;
      4'd5:    r = 8'h0e;
      4'd6:    r = 8'h2b;
      4'd7:    r = 8'h05;
      4'd8:    r = 8'h06;
      4'd9:    r = 8'h07;
      4'd10:   r = 8'h30;
      4'd11:   r = 8'h1f;
      4'd12:   r = 8'h30;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/rsa_signature_padding_check.sv @@
// an accepted item is held in the input register, checked from there, and its verdict loaded into the result reg
// throughput: one item per cycle, set by the single check stage between input and result regs, unless stalled
// by a verdict item waiting on a stuck result slot; a new item is taken while a verdict waits, unless the held
// item is itself a verdict. reset: async active low; clears block state, hash load count and valids,
// modulus_size to 256. stored hash bytes are not cleared by reset
module rsa_signature_padding_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rsapc_pkg::in_item_t              in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rsapc_pkg::out_item_t             out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsapc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rsapc_pkg::CfgDataW-1:0]   pwdata,
  output logic [rsapc_pkg::CfgDataW-1:0]   prdata,
  output logic                             pready
);
  import rsapc_pkg::*;
  `include "rsa_signature_padding_check_assert.svh"

  logic          in_valid_q, in_valid_d;
  in_item_t      in_item_q;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q;
  logic [MsW-1:0] ms_q;

  logic          in_fire;
  logic          proc_fire;
  logic          is_verdict;
  logic          verdict_fire;
  logic          ok_agrees;
  logic          verdict_stuck;
  hash_wr_t      hash_wr;
  blk_op_t       blk_op;
  logic [HashIdxW-1:0] hash_idx;
  logic [7:0]    hash_byte;
  fail_reason_e  fail_reason;
  logic          cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CfgAddrW-1] == RegModulusSize);
  assign prdata = (paddr[CfgAddrW-1] == RegModulusSize) ? CfgDataW'(ms_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MsW'(MsReset);
    end else if (cfg_wr) begin
      ms_q <= pwdata[MsW-1:0];
    end
  end

  // the held item moves on unless it is a verdict and the result slot is stuck
  assign is_verdict = (in_item_q.req_type == ReqBlock) && in_item_q.last_byte;
  assign proc_fire  = in_valid_q && (!is_verdict || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_item_i;
    end
  end

  assign hash_wr.en   = proc_fire && (in_item_q.req_type == ReqHash);
  assign hash_wr.data = in_item_q.data_byte;
  assign blk_op.fire  = proc_fire && (in_item_q.req_type == ReqBlock);
  assign blk_op.last  = in_item_q.last_byte;
  assign blk_op.data  = in_item_q.data_byte;

  rsapc_hash_store u_hash_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hash_wr),
    .rd_idx_i  (hash_idx),
    .rd_data_o (hash_byte)
  );

  rsapc_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .blk_i          (blk_op),
    .modulus_size_i (ms_q),
    .hash_byte_i    (hash_byte),
    .hash_idx_o     (hash_idx),
    .fail_reason_o  (fail_reason)
  );

  assign verdict_fire = blk_op.fire && blk_op.last;

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (verdict_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict_fire) begin
      out_item_q.signature_ok <= (fail_reason == FAIL_NONE);
      out_item_q.fail_reason  <= fail_reason;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign ok_agrees     = out_item_q.signature_ok == (out_item_q.fail_reason == FAIL_NONE);
  assign verdict_stuck = out_valid_q && !out_ready_i && in_valid_q && is_verdict;

  `RSAPC_ASSERT_NEXT(a_verdict_lands, clk_i, rst_ni, verdict_fire, out_valid_q, "verdict lost")
  `RSAPC_ASSERT_NOW(a_ok_matches, clk_i, rst_ni, out_valid_q, ok_agrees, "ok flag mismatch")
  `RSAPC_ASSERT_NOW(a_verdict_held, clk_i, rst_ni, verdict_stuck, !in_ready_o, "item moved")

endmodule

@@ hdl/rsapc_hash_store.sv @@
// expected hash byte store, filled in reverse order by a wrapping load counter
module rsapc_hash_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rsapc_pkg::hash_wr_t                wr_i,
  input  logic [rsapc_pkg::HashIdxW-1:0]     rd_idx_i,
  output logic [7:0]                         rd_data_o
);
  import rsapc_pkg::*;

  logic [7:0]          mem_q [HashBytes];
  logic [HashIdxW-1:0] cnt_q, cnt_d;
  logic [HashIdxW-1:0] wr_idx;

  assign wr_idx = HashIdxW'(HashBytes - 1) - cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i.en) begin
      cnt_d = (cnt_q == HashIdxW'(HashBytes - 1)) ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.data;
    end
  end

  // block bytes only look here while the position is below the hash length
  assign rd_data_o = (rd_idx_i < HashIdxW'(HashBytes)) ? mem_q[rd_idx_i] : ByteZero;

endmodule

@@ hdl/rsapc_check.sv @@
// per-byte block state update and verdict for the padding check
module rsapc_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rsapc_pkg::blk_op_t             blk_i,
  input  logic [rsapc_pkg::MsW-1:0]      modulus_size_i,
  input  logic [7:0]                     hash_byte_i,
  output logic [rsapc_pkg::HashIdxW-1:0] hash_idx_o,
  output rsapc_pkg::fail_reason_e        fail_reason_o
);
  import rsapc_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic              hash_ok_q, hash_ok_d;
  logic              long_ok_q, long_ok_d;
  logic              short_ok_q, short_ok_d;
  logic [WinLen-1:0] ff_q, ff_d;
  logic [WinLen-1:0] zero_q, zero_d;
  logic              tail_ok_q, tail_ok_d;

  logic [PosW-1:0]    ms;
  logic [PosW:0]      ms_w;
  logic [PosW-1:0]    win_off;
  logic [WinIdxW-1:0] k_idx;
  logic [WinIdxW-1:0] zp_k;
  logic [PosW-1:0]    needed;
  logic               in_buf, in_hash, in_win;
  logic               pad_ok;

  assign ms      = PosW'(modulus_size_i);
  assign ms_w    = (PosW + 1)'(modulus_size_i);
  assign win_off = pos_q - PosW'(WinBase);
  assign k_idx   = win_off[WinIdxW-1:0];
  assign in_buf  = pos_q < PosW'(MaxBlockBytes);
  assign in_hash = pos_q < PosW'(HashBytes);
  assign in_win  = (pos_q >= PosW'(WinBase)) && (pos_q <= PosW'(LastWinPos));
  assign hash_idx_o = pos_q[HashIdxW-1:0];

  // state after taking the current byte
  always_comb begin
    hash_ok_d  = hash_ok_q;
    long_ok_d  = long_ok_q;
    short_ok_d = short_ok_q;
    ff_d       = ff_q;
    zero_d     = zero_q;
    tail_ok_d  = tail_ok_q;
    if (in_buf) begin
      if (in_hash && blk_i.data != hash_byte_i) begin
        hash_ok_d = 1'b0;
      end
      if (in_win) begin
        if (k_idx < WinIdxW'(LongLen) && blk_i.data != long_prefix_byte(k_idx)) begin
          long_ok_d = 1'b0;
        end
        if (k_idx < WinIdxW'(ShortLen) && blk_i.data != short_prefix_byte(k_idx)) begin
          short_ok_d = 1'b0;
        end
        if (blk_i.data == ByteFf) begin
          ff_d[k_idx] = 1'b1;
        end
        if (blk_i.data == ByteZero) begin
          zero_d[k_idx] = 1'b1;
        end
      end
      if (pos_q == ms && blk_i.data != ByteZero) begin
        tail_ok_d = 1'b0;
      end
      if (ms != '0 && pos_q == ms - 1'b1 && blk_i.data != ByteOne) begin
        tail_ok_d = 1'b0;
      end
      if (pos_q > PosW'(LastWinPos) && ((PosW + 1)'(pos_q) + 1'b1) < ms_w &&
          blk_i.data != ByteFf) begin
        tail_ok_d = 1'b0;
      end
    end
  end

  // verdict from the updated state
  always_comb begin
    if (long_ok_d) begin
      zp_k = WinIdxW'(LongLen);
    end else if (short_ok_d) begin
      zp_k = WinIdxW'(ShortLen);
    end else begin
      zp_k = '0;
    end
    pad_ok = tail_ok_d && zero_d[zp_k];
    for (int k = 0; k < WinLen; k++) begin
      if (WinIdxW'(k) > zp_k && (PosW + 1)'(WinBase + k + 1) < ms_w && !ff_d[k]) begin
        pad_ok = 1'b0;
      end
    end
    needed = (ms > PosW'(LastWinPos)) ? ms : PosW'(LastWinPos);
    if (!hash_ok_d) begin
      fail_reason_o = FAIL_HASH;
    end else if (needed >= PosW'(MaxBlockBytes) || pos_q < needed) begin
      fail_reason_o = FAIL_SHORT;
    end else if (!pad_ok) begin
      fail_reason_o = FAIL_PAD;
    end else begin
      fail_reason_o = FAIL_NONE;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (in_buf) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hash_ok_q  <= 1'b1;
      long_ok_q  <= 1'b1;
      short_ok_q <= 1'b1;
      ff_q       <= '0;
      zero_q     <= '0;
      tail_ok_q  <= 1'b1;
    end else if (blk_i.fire) begin
      if (blk_i.last) begin
        // verdict given, start a fresh block
        pos_q      <= '0;
        hash_ok_q  <= 1'b1;
        long_ok_q  <= 1'b1;
        short_ok_q <= 1'b1;
        ff_q       <= '0;
        zero_q     <= '0;
        tail_ok_q  <= 1'b1;
      end else begin
        pos_q      <= pos_d;
        hash_ok_q  <= hash_ok_d;
        long_ok_q  <= long_ok_d;
        short_ok_q <= short_ok_d;
        ff_q       <= ff_d;
        zero_q     <= zero_d;
        tail_ok_q  <= tail_ok_d;
      end
    end
  end

endmodule
